@@ hdl/dvp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dvp_pkg: shared types and constants of the dotted version parser
// Beat structs for both channels, the one-hot parse phase and the byte codes.
// ----------------------------------------------------------------------------
package dvp_pkg;

    // width of one parsed number; overflow beyond this yields zero
    localparam int NUM_BITS = 32;
    // width of one reported part
    localparam int PART_W   = 32;
    // number width plus room for a times-ten-plus-digit step
    localparam int WIDE_W   = NUM_BITS + 4;

    typedef logic [NUM_BITS-1:0] num_t;
    typedef logic [WIDE_W-1:0]   wide_t;
    typedef logic [PART_W-1:0]   part_t;

    // byte codes
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2e;

    // input beat: one text byte or the end mark
    typedef struct packed {
        logic [7:0] character;
        logic       ends_text;
    } text_beat_t;

    // output beat: the four parts
    typedef struct packed {
        part_t first_part;
        part_t second_part;
        part_t third_part;
        part_t fourth_part;
    } parts_beat_t;

    // parse phase, one-hot
    typedef enum logic [8:0] {
        PH_SKIP   = 9'b0_0000_0001,
        PH_NUM1   = 9'b0_0000_0010,
        PH_DOT1   = 9'b0_0000_0100,
        PH_NUM2   = 9'b0_0000_1000,
        PH_DOT2   = 9'b0_0001_0000,
        PH_NUM3   = 9'b0_0010_0000,
        PH_DOT3   = 9'b0_0100_0000,
        PH_NUM4   = 9'b0_1000_0000,
        PH_FROZEN = 9'b1_0000_0000
    } phase_t;

    // handshake between the input stage and the parse core
    typedef struct packed {
        logic       valid;
        text_beat_t beat;
    } stage_t;

    // reported form of a number
    function automatic part_t to_part(input num_t v);
        return PART_W'(v);
    endfunction

endpackage : dvp_pkg
`default_nettype wire

@@ hdl/dvp_in_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dvp_in_stage: input register of the dotted version parser
// Captures one text beat and holds it until the parse core takes it.
// ----------------------------------------------------------------------------
module dvp_in_stage
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                text_valid,
    output logic                     text_stall,
    input  wire dvp_pkg::text_beat_t text,
    output dvp_pkg::stage_t          stage,
    input  wire logic                take
);
    import dvp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    text_beat_t beat_reg;
    logic       load;

    // stall only while a held beat cannot move on
    assign text_stall = valid_reg && !take;
    assign load       = text_valid && !text_stall;

    // valid tracking
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= text;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.beat  = beat_reg;

endmodule : dvp_in_stage
`default_nettype wire

@@ hdl/dvp_parse_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dvp_parse_core: parse state and result register
// Steps the phases one byte per cycle; emits parts on end once no result stalls.
// ----------------------------------------------------------------------------
module dvp_parse_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dvp_pkg::stage_t  stage,
    output logic                  take,
    output logic                  parts_valid,
    input  wire logic             parts_stall,
    output dvp_pkg::parts_beat_t  parts
);
    import dvp_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    num_t        acc_reg;
    num_t        acc_next;
    logic        ovf_reg;
    logic        ovf_next;
    num_t        pend_reg;
    num_t        pend_next;
    num_t        part_reg [4];
    num_t        part_next [4];
    logic        out_valid_reg;
    logic        out_valid_next;
    parts_beat_t out_reg;

    logic        step;
    logic        is_end;
    logic        dig;
    logic        is_dot;
    logic [3:0]  digit;
    num_t        digit_num;
    wide_t       prod;
    logic        carry;
    logic        add_ovf;
    num_t        add_acc;
    num_t        add_value;
    num_t        cur_value;

    // an end beat waits only when the result register is still occupied and stalled
    assign is_end = stage.beat.ends_text;
    assign take   = stage.valid && !(is_end && out_valid_reg && parts_stall);
    assign step   = take;

    // byte classification
    assign dig       = (stage.beat.character >= CHAR_ZERO) &&
                       (stage.beat.character <= CHAR_NINE);
    assign is_dot    = (stage.beat.character == CHAR_DOT);
    assign digit     = stage.beat.character[3:0];
    assign digit_num = NUM_BITS'(digit);

    // times ten plus digit, with carry out as overflow
    assign prod      = wide_t'({acc_reg, 3'b000}) + wide_t'({acc_reg, 1'b0})
                     + wide_t'(digit);
    assign carry     = |prod[WIDE_W-1:NUM_BITS];
    assign add_ovf   = ovf_reg || carry;
    assign add_acc   = add_ovf ? acc_reg : prod[NUM_BITS-1:0];
    assign add_value = add_ovf ? '0 : add_acc;
    assign cur_value = ovf_reg ? '0 : acc_reg;

    // phase machine
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        pend_next  = pend_reg;
        for (int i = 0; i < 4; i++)
        begin
            part_next[i] = part_reg[i];
        end

        if (step)
        begin
            if (is_end)
            begin
                phase_next = PH_SKIP;
                acc_next   = '0;
                ovf_next   = 1'b0;
                pend_next  = '0;
                for (int i = 0; i < 4; i++)
                begin
                    part_next[i] = '0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_SKIP:
                    begin
                        if (dig)
                        begin
                            acc_next   = digit_num;
                            ovf_next   = 1'b0;
                            phase_next = PH_NUM1;
                        end
                    end
                    PH_NUM1:
                    begin
                        if (dig)
                        begin
                            acc_next = add_acc;
                            ovf_next = add_ovf;
                        end
                        else if (is_dot)
                        begin
                            pend_next  = cur_value;
                            phase_next = PH_DOT1;
                        end
                        else
                        begin
                            phase_next = PH_FROZEN;
                        end
                    end
                    PH_DOT1, PH_DOT2, PH_DOT3:
                    begin
                        if (dig)
                        begin
                            acc_next = digit_num;
                            ovf_next = 1'b0;
                            case (phase_reg)
                                PH_DOT1:
                                begin
                                    part_next[0] = pend_reg;
                                    part_next[1] = digit_num;
                                    phase_next   = PH_NUM2;
                                end
                                PH_DOT2:
                                begin
                                    part_next[2] = digit_num;
                                    phase_next   = PH_NUM3;
                                end
                                default:
                                begin
                                    part_next[3] = digit_num;
                                    phase_next   = PH_NUM4;
                                end
                            endcase
                        end
                        else
                        begin
                            phase_next = PH_FROZEN;
                        end
                    end
                    PH_NUM2, PH_NUM3, PH_NUM4:
                    begin
                        if (dig)
                        begin
                            acc_next = add_acc;
                            ovf_next = add_ovf;
                            case (phase_reg)
                                PH_NUM2: part_next[1] = add_value;
                                PH_NUM3: part_next[2] = add_value;
                                default: part_next[3] = add_value;
                            endcase
                        end
                        else if (is_dot && phase_reg == PH_NUM2)
                        begin
                            phase_next = PH_DOT2;
                        end
                        else if (is_dot && phase_reg == PH_NUM3)
                        begin
                            phase_next = PH_DOT3;
                        end
                        else
                        begin
                            phase_next = PH_FROZEN;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_FROZEN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= '0;
            for (int i = 0; i < 4; i++)
            begin
                part_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            for (int i = 0; i < 4; i++)
            begin
                part_reg[i] <= part_next[i];
            end
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && is_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !parts_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded by the end beat
    always_ff @(posedge clk)
    begin
        if (step && is_end)
        begin
            out_reg.first_part  <= to_part(part_reg[0]);
            out_reg.second_part <= to_part(part_reg[1]);
            out_reg.third_part  <= to_part(part_reg[2]);
            out_reg.fourth_part <= to_part(part_reg[3]);
        end
    end

    assign parts_valid = out_valid_reg;
    assign parts       = out_reg;

    // an end beat never overwrites a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_end) |-> !(out_valid_reg && parts_stall))
        else $error("result overwritten while stalled");

    // an end beat re-arms the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_end) |=> (phase_reg == PH_SKIP && !ovf_reg && part_reg[0] == '0))
        else $error("parser not re-armed after end beat");

    // a frozen parser stays frozen until the end beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FROZEN && !(step && is_end)) |=> (phase_reg == PH_FROZEN))
        else $error("frozen parser resumed");

    // a result appears only after an end beat was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step && is_end))
        else $error("result without end beat");

endmodule : dvp_parse_core
`default_nettype wire

@@ hdl/dotted_version_parser_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dotted_version_parser_unit: permissive dotted version parser
// Reads a text byte by byte and reports up to four decimal parts on end.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  text    | in  | text_valid/text_stall   | character[7:0], ends_text
//  parts   | out | parts_valid/parts_stall | first..fourth_part[31:0]
//
//  one text beat per cycle while no end beat waits on a stalled result; each byte
//  passes the parse core's times-ten add and phase update; an accepted end beat
//  sits in the input register until taken, then parts_valid rises from the result register
//  reset clears the phase, accumulator, parts and both valid flags
//  a stalled result blocks only the next end beat; ordinary bytes still flow
// ----------------------------------------------------------------------------
module dotted_version_parser_unit
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 text_valid,
    output logic                      text_stall,
    input  wire dvp_pkg::text_beat_t  text,
    output logic                      parts_valid,
    input  wire logic                 parts_stall,
    output dvp_pkg::parts_beat_t      parts
);
    import dvp_pkg::*;

    stage_t stage;
    logic   take;

    // input register
    dvp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text),
        .stage      (stage),
        .take       (take)
    );

    // parse state and result register
    dvp_parse_core u_parse_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .take        (take),
        .parts_valid (parts_valid),
        .parts_stall (parts_stall),
        .parts       (parts)
    );

endmodule : dotted_version_parser_unit
`default_nettype wire

@@ tb/dvp_parts_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dvp_parts_checker: result checker for the dotted version parser
// Watches both channels, tracks the parse of every accepted text beat and
// compares each accepted parts beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module dvp_parts_checker
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 text_valid,
    input  wire logic                 text_stall,
    input  wire dvp_pkg::text_beat_t  text,
    input  wire logic                 parts_valid,
    input  wire logic                 parts_stall,
    input  wire dvp_pkg::parts_beat_t parts,
    output int                        mismatches,
    output int                        pending
);
    import dvp_pkg::*;

    // shadow parse state
    phase_t                phase;
    logic [NUM_BITS-1:0]   number_acc;
    logic                  number_ovf;
    logic [NUM_BITS-1:0]   held_first;
    logic [NUM_BITS-1:0]   kept_parts [4];
    int                    fail_total;

    // predicted parts beats, oldest first
    parts_beat_t           expected_parts [$];

    // back to the state after reset
    task automatic clear_parse();
        phase      = PH_SKIP;
        number_acc = '0;
        number_ovf = 1'b0;
        held_first = '0;
        for (int k = 0; k < 4; k++)
            kept_parts[k] = '0;
    endtask

    // value of the number being read, zero once it overflowed
    function automatic logic [NUM_BITS-1:0] number_now();
        return number_ovf ? '0 : number_acc;
    endfunction

    // part slot of a number phase
    function automatic int slot_of(input phase_t ph);
        case (ph)
            PH_NUM2: return 1;
            PH_NUM3: return 2;
            PH_NUM4: return 3;
            default: return 0;
        endcase
    endfunction

    // times ten plus digit, with overflow detection past NUM_BITS
    task automatic push_digit(input logic [3:0] dval);
        logic [NUM_BITS+3:0] grown;
        if (!number_ovf)
        begin
            grown = {4'b0, number_acc} * 10 + dval;
            if (grown[NUM_BITS+3:NUM_BITS] != '0)
                number_ovf = 1'b1;
            else
                number_acc = grown[NUM_BITS-1:0];
        end
    endtask

    // one text byte through the parse phases
    task automatic parse_byte(input logic [7:0] ch);
        logic       is_dig;
        logic       is_dot;
        logic [3:0] dval;
        is_dig = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        is_dot = (ch == CHAR_DOT);
        dval   = 4'(ch - CHAR_ZERO);
        case (phase)
            PH_SKIP:
                if (is_dig)
                begin
                    number_acc = NUM_BITS'(dval);
                    number_ovf = 1'b0;
                    phase      = PH_NUM1;
                end
            PH_NUM1:
                if (is_dig)
                    push_digit(dval);
                else if (is_dot)
                begin
                    held_first = number_now();
                    phase      = PH_DOT1;
                end
                else
                    phase = PH_FROZEN;
            PH_DOT1, PH_DOT2, PH_DOT3:
                if (is_dig)
                begin
                    // first part only counts once the second has begun
                    if (phase == PH_DOT1)
                        kept_parts[0] = held_first;
                    number_acc = NUM_BITS'(dval);
                    number_ovf = 1'b0;
                    phase      = phase_t'(phase << 1);
                    kept_parts[slot_of(phase)] = number_now();
                end
                else
                    phase = PH_FROZEN;
            PH_NUM2, PH_NUM3, PH_NUM4:
                if (is_dig)
                begin
                    push_digit(dval);
                    kept_parts[slot_of(phase)] = number_now();
                end
                else if (is_dot && phase != PH_NUM4)
                    phase = phase_t'(phase << 1);
                else
                    phase = PH_FROZEN;
            default:
                phase = PH_FROZEN;
        endcase
    endtask

    // compare one accepted parts beat with the oldest prediction
    task automatic check_parts(input parts_beat_t seen);
        parts_beat_t want;
        part_t       want_f [4];
        part_t       seen_f [4];
        if (expected_parts.size() == 0)
        begin
            $display("%0t: unexpected parts beat %h", $time, seen);
            fail_total++;
        end
        else
        begin
            want   = expected_parts.pop_front();
            want_f = '{want.first_part, want.second_part, want.third_part, want.fourth_part};
            seen_f = '{seen.first_part, seen.second_part, seen.third_part, seen.fourth_part};
            for (int k = 0; k < 4; k++)
                if (seen_f[k] !== want_f[k])
                begin
                    $display("%0t: part %0d expected %0d actual %0d",
                             $time, k, want_f[k], seen_f[k]);
                    fail_total++;
                end
        end
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            expected_parts.delete();
            fail_total = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (text_valid && !text_stall)
            begin
                if (text.ends_text)
                begin
                    expected_parts.push_back('{
                        first_part:  PART_W'(kept_parts[0]),
                        second_part: PART_W'(kept_parts[1]),
                        third_part:  PART_W'(kept_parts[2]),
                        fourth_part: PART_W'(kept_parts[3])
                    });
                    clear_parse();
                end
                else
                    parse_byte(text.character);
            end
            if (parts_valid && !parts_stall)
                check_parts(parts);
            mismatches <= fail_total;
            pending    <= expected_parts.size();
        end
    end

endmodule : dvp_parts_checker

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the dotted version parser
// Sends directed texts, then random version strings (mostly well formed,
// some broken, some noise) with random gaps and result stalls; the checker
// predicts the parts of every end beat and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
    import dvp_pkg::*;

    localparam int TEXT_BEATS  = 1450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        text_valid  = 1'b0;
    logic        text_stall;
    text_beat_t  text_beat   = '0;
    logic        parts_valid;
    logic        parts_stall = 1'b0;
    parts_beat_t parts_beat;

    int          mismatches;
    int          pending;
    int          beats_sent  = 0;
    int          cycles      = 0;
    logic        quiet;
    logic [7:0]  text_bytes [$];

    dotted_version_parser_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text        (text_beat),
        .parts_valid (parts_valid),
        .parts_stall (parts_stall),
        .parts       (parts_beat)
    );

    dvp_parts_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text        (text_beat),
        .parts_valid (parts_valid),
        .parts_stall (parts_stall),
        .parts       (parts_beat),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // clock
    always #10 clk = ~clk;

    // stretch with no idling on either side
    assign quiet = (beats_sent >= 500) && (beats_sent < 800);

    // result side stalls at random
    always @(posedge clk)
        parts_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 19);

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // one text beat, held until accepted
    task automatic send_beat(input logic [7:0] ch, input logic fin);
        while (!quiet && $urandom_range(0, 99) < 19)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid          <= 1'b1;
        text_beat.character <= ch;
        text_beat.ends_text <= fin;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // queued bytes, then the end beat with a random byte field
    task automatic send_text();
        foreach (text_bytes[i])
            send_beat(text_bytes[i], 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        text_bytes.delete();
    endtask

    // directed text from a string
    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            text_bytes.push_back(s[i]);
        send_text();
    endtask

    // any byte that is not a digit
    function automatic logic [7:0] junk_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            c = c ^ 8'h40;
        return c;
    endfunction

    function automatic logic [7:0] digit_byte(input int lo);
        return CHAR_ZERO + 8'($urandom_range(lo, 9));
    endfunction

    // one decimal number, biased to the edges of the number range
    task automatic put_number();
        longint unsigned v;
        string           digits;
        v = 0;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom_range(0, 9);
            3, 4:    v = $urandom_range(0, 99999);
            5:       v = $urandom();
            6:       v = 64'hFFFF_FFFF;
            7:       v = 64'h1_0000_0000 + $urandom_range(0, 3);
            8:
            begin
                // leading zeros
                repeat ($urandom_range(1, 3))
                    text_bytes.push_back(CHAR_ZERO);
                v = $urandom_range(0, 999);
            end
            default:
            begin
                // long run that overflows
                text_bytes.push_back(digit_byte(1));
                repeat ($urandom_range(10, 19))
                    text_bytes.push_back(digit_byte(0));
                return;
            end
        endcase
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++)
            text_bytes.push_back(digits[i]);
    endtask

    // random version text: mostly well formed, some broken tails, some noise
    task automatic random_text();
        int parts_n;
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(0, 10))
                text_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                text_bytes.push_back(junk_byte());
            parts_n = $urandom_range(1, 5);
            for (int k = 0; k < parts_n; k++)
            begin
                if (k > 0)
                    text_bytes.push_back(CHAR_DOT);
                put_number();
            end
            if ($urandom_range(0, 99) < 25)
            begin
                case ($urandom_range(0, 3))
                    0: text_bytes.push_back(CHAR_DOT);
                    1:
                    begin
                        text_bytes.push_back(junk_byte());
                        put_number();
                    end
                    2:
                    begin
                        text_bytes.push_back(CHAR_DOT);
                        text_bytes.push_back(CHAR_DOT);
                        put_number();
                    end
                    default:
                    begin
                        text_bytes.push_back(CHAR_DOT);
                        text_bytes.push_back(junk_byte());
                    end
                endcase
            end
        end
        send_text();
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty text, all four parts after a junk byte plus a fifth part, double dot,
        // first part without a second, junk after a number
        send_string("");
        send_string("\3771.2.3.4.5");
        send_string("1..2");
        send_string("1.");
        send_string("9x5");

        while (beats_sent < TEXT_BEATS)
            random_text();

        text_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule : tb

@@ files.f @@
hdl/dvp_pkg.sv
hdl/dvp_in_stage.sv
hdl/dvp_parse_core.sv
hdl/dotted_version_parser_unit.sv
tb/dvp_parts_checker.sv
tb/tb.sv
